### rtl/core/btpc_pkg.sv
// Shared types and constants for the barometer compensation block.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
package btpc_pkg;

    typedef struct packed {
        logic        opcode;
        logic [23:0] raw_reading;
    } in_beat_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] result_value;
        logic               result_valid;
    } out_beat_t;

    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // datapath micro-ops
    localparam logic [4:0] U_LOAD  = 5'd0;
    localparam logic [4:0] U_T1    = 5'd1;
    localparam logic [4:0] U_T2    = 5'd2;
    localparam logic [4:0] U_TDIV  = 5'd3;
    localparam logic [4:0] U_TFIN  = 5'd4;
    localparam logic [4:0] U_P1    = 5'd5;
    localparam logic [4:0] U_P2    = 5'd6;
    localparam logic [4:0] U_P3    = 5'd7;
    localparam logic [4:0] U_P4    = 5'd8;
    localparam logic [4:0] U_P5    = 5'd9;
    localparam logic [4:0] U_P6    = 5'd10;
    localparam logic [4:0] U_P7    = 5'd11;
    localparam logic [4:0] U_P8    = 5'd12;
    localparam logic [4:0] U_P9    = 5'd13;
    localparam logic [4:0] U_PDIV  = 5'd14;
    localparam logic [4:0] U_P10   = 5'd15;
    localparam logic [4:0] U_P11   = 5'd16;
    localparam logic [4:0] U_P12   = 5'd17;
    localparam logic [4:0] U_P13   = 5'd18;
    localparam logic [4:0] U_NOP   = 5'd19;

    typedef struct packed {
        logic [4:0] uop;
        logic       div_start;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic zero_div;
    } dp_stat_t;

endpackage

### rtl/core/btpc_ctrl.sv
// Sequencer for the compensation steps.
// Depends on btpc_pkg; drives btpc_datapath through dp_cmd_t.
`timescale 1ns / 1ps
module btpc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               in_opcode,
    output logic               out_valid,
    input  logic               out_stall,
    output btpc_pkg::dp_cmd_t  cmd,
    input  btpc_pkg::dp_stat_t stat
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0] state_reg, state_next;
    logic [4:0] uop_reg, uop_next;
    logic       start_div;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        uop_next   = uop_reg;
        start_div  = 1'b0;
        cmd.uop    = btpc_pkg::U_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.uop    = btpc_pkg::U_LOAD;
                    state_next = S_STEP;
                    uop_next   = (in_opcode == btpc_pkg::OP_TEMP) ? btpc_pkg::U_T1
                                                                  : btpc_pkg::U_P1;
                end
            end
            S_STEP:
            begin
                cmd.uop = uop_reg;
                unique case (uop_reg)
                    btpc_pkg::U_T2, btpc_pkg::U_P9:
                    begin
                        if (stat.zero_div)
                            state_next = S_OUT;
                        else
                        begin
                            start_div  = 1'b1;
                            state_next = S_DIV;
                        end
                        uop_next = uop_reg + 5'd1;
                    end
                    btpc_pkg::U_TFIN, btpc_pkg::U_P13:
                        state_next = S_OUT;
                    default:
                        uop_next = uop_reg + 5'd1;
                endcase
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.uop    = uop_reg;
                    uop_next   = uop_reg + 5'd1;
                    state_next = S_STEP;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        cmd.div_start = start_div;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            uop_reg   <= btpc_pkg::U_NOP;
        end
        else
        begin
            state_reg <= state_next;
            uop_reg   <= uop_next;
        end
    end
endmodule

### rtl/core/btpc_datapath.sv
// Registers, one shared multiplier and a radix-2 divider for compensation.
// Depends on btpc_pkg; commanded by btpc_ctrl.
`timescale 1ns / 1ps
module btpc_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  btpc_pkg::dp_cmd_t   cmd,
    output btpc_pkg::dp_stat_t  stat,
    input  btpc_pkg::in_beat_t  in_beat,
    input  logic [31:0]         cal_ac1_ac2,
    input  logic [31:0]         cal_ac3_ac4,
    input  logic [31:0]         cal_ac5_ac6,
    input  logic [31:0]         cal_b1_b2,
    input  logic [31:0]         cal_mc_md,
    input  logic [1:0]          oversampling,
    output btpc_pkg::out_beat_t out_beat
);
    logic [31:0] b5_reg, b5_next;
    logic [31:0] b6_reg, sq_reg, a_reg, b_reg, c_reg, up_reg;
    logic [31:0] a_next, b_next, c_next, up_next, b6_next, sq_next;
    logic [31:0] b3_reg, b3_next;
    logic [23:0] raw_reg;
    logic        kind_reg, valid_reg, valid_next;
    logic [31:0] val_reg, val_next;

    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [1:0]  oss;

    // divider
    logic [31:0] dq_reg, dq_next, dr_reg, dr_next, dd_reg, dd_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic        dneg_reg, dneg_next;
    logic [31:0] dn_in, dd_in;
    logic        dsigned;
    logic [32:0] trial;
    logic [31:0] quot;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        asr = 32'($signed(v) >>> s);
    endfunction

    assign ac1 = sx16(cal_ac1_ac2[31:16]);
    assign ac2 = sx16(cal_ac1_ac2[15:0]);
    assign ac3 = sx16(cal_ac3_ac4[31:16]);
    assign ac4 = {16'd0, cal_ac3_ac4[15:0]};
    assign ac5 = {16'd0, cal_ac5_ac6[31:16]};
    assign ac6 = {16'd0, cal_ac5_ac6[15:0]};
    assign b1  = sx16(cal_b1_b2[31:16]);
    assign b2  = sx16(cal_b1_b2[15:0]);
    assign mc  = sx16(cal_mc_md[31:16]);
    assign md  = sx16(cal_mc_md[15:0]);
    assign oss = oversampling;

    assign prod = mul_a * mul_b;
    assign quot = dneg_reg ? (32'd0 - dq_reg) : dq_reg;

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (cmd.uop)
            btpc_pkg::U_T1:  begin mul_a = {8'd0, raw_reg} - ac6; mul_b = ac5; end
            btpc_pkg::U_P1:  begin mul_a = b6_reg; mul_b = b6_reg; end
            btpc_pkg::U_P2:  begin mul_a = b2;     mul_b = sq_reg; end
            btpc_pkg::U_P3:  begin mul_a = ac2;    mul_b = b6_reg; end
            btpc_pkg::U_P5:  begin mul_a = ac3;    mul_b = b6_reg; end
            btpc_pkg::U_P6:  begin mul_a = b1;     mul_b = sq_reg; end
            btpc_pkg::U_P7:  begin mul_a = ac4;    mul_b = c_reg + 32'd32768; end
            btpc_pkg::U_P8:  begin mul_a = up_reg - b3_reg; mul_b = 32'd50000 >> oss; end
            btpc_pkg::U_P10: begin mul_a = asr(a_reg, 8); mul_b = asr(a_reg, 8); end
            btpc_pkg::U_P11: begin mul_a = b_reg;  mul_b = 32'd3038; end
            btpc_pkg::U_P12: begin mul_a = a_reg;  mul_b = 32'd0 - 32'd7357; end
            default: ;
        endcase
    end

    always_comb
    begin
        logic [31:0] t;
        logic [31:0] nb3;
        t = 32'd0;
        nb3 = 32'd0;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; up_next = up_reg;
        b6_next = b6_reg; sq_next = sq_reg; b5_next = b5_reg; b3_next = b3_reg;
        valid_next = valid_reg; val_next = val_reg;
        dn_in = 32'd0; dd_in = 32'd0; dsigned = 1'b0;
        unique case (cmd.uop)
            btpc_pkg::U_LOAD:
            begin
                valid_next = 1'b1;
                val_next   = 32'd0;
                up_next    = {8'd0, in_beat.raw_reading} >> (4'd8 - {2'd0, oss});
                b6_next    = b5_reg - 32'd4000;
            end
            btpc_pkg::U_T1: a_next = asr(prod, 15);
            btpc_pkg::U_T2:
            begin
                b_next = a_reg + md;
                if (a_reg + md == 32'd0)
                    valid_next = 1'b0;
                dn_in = mc << 11; dd_in = a_reg + md; dsigned = 1'b1;
            end
            btpc_pkg::U_TDIV: b5_next = a_reg + quot;
            btpc_pkg::U_TFIN: val_next = asr(b5_reg + 32'd8, 4);
            btpc_pkg::U_P1: sq_next = asr(prod, 12);
            btpc_pkg::U_P2: a_next = asr(prod, 11);
            btpc_pkg::U_P3: a_next = a_reg + asr(prod, 11);
            btpc_pkg::U_P4:
            begin
                t = ((ac1 << 2) + a_reg) << oss;
                t = t + 32'd2;
                // truncating signed /4
                nb3 = t[31] ? (32'd0 - ((32'd0 - t) >> 2)) : (t >> 2);
                b3_next = nb3;
            end
            btpc_pkg::U_P5: a_next = asr(prod, 13);
            btpc_pkg::U_P6: c_next = asr(a_reg + asr(prod, 16) + 32'd2, 2);
            btpc_pkg::U_P7: b_next = prod >> 15;
            btpc_pkg::U_P8: a_next = prod;
            btpc_pkg::U_P9:
            begin
                if (b_reg == 32'd0)
                    valid_next = 1'b0;
                dn_in = a_reg[31] ? a_reg : (a_reg << 1);
                dd_in = b_reg;
            end
            btpc_pkg::U_PDIV: a_next = a_reg[31] ? (dq_reg << 1) : dq_reg;
            btpc_pkg::U_P10: b_next = prod;
            btpc_pkg::U_P11: b_next = asr(prod, 16);
            btpc_pkg::U_P12: c_next = asr(prod, 16);
            btpc_pkg::U_P13: val_next = a_reg + asr(b_reg + c_reg + 32'd3791, 4);
            default: ;
        endcase
    end

    assign stat.zero_div = (dd_in == 32'd0);
    assign stat.div_busy = (dcnt_reg != 6'd0);
    assign trial = {dr_reg, dq_reg[31]} - {1'b0, dd_reg};

    always_comb
    begin
        dq_next = dq_reg; dr_next = dr_reg; dd_next = dd_reg;
        dcnt_next = dcnt_reg; dneg_next = dneg_reg;
        if (cmd.div_start)
        begin
            dq_next   = (dsigned && dn_in[31]) ? (32'd0 - dn_in) : dn_in;
            dd_next   = (dsigned && dd_in[31]) ? (32'd0 - dd_in) : dd_in;
            dneg_next = dsigned && (dn_in[31] != dd_in[31]);
            dr_next   = 32'd0;
            dcnt_next = 6'd32;
        end
        else if (dcnt_reg != 6'd0)
        begin
            if (!trial[32])
            begin
                dr_next = trial[31:0];
                dq_next = {dq_reg[30:0], 1'b1};
            end
            else
            begin
                dr_next = {dr_reg[30:0], dq_reg[31]};
                dq_next = {dq_reg[30:0], 1'b0};
            end
            dcnt_next = dcnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b5_reg   <= 32'd0;
            dcnt_reg <= 6'd0;
        end
        else
        begin
            b5_reg   <= b5_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.uop == btpc_pkg::U_LOAD)
        begin
            raw_reg  <= in_beat.raw_reading;
            kind_reg <= in_beat.opcode;
        end
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; up_reg <= up_next;
        b6_reg <= b6_next; sq_reg <= sq_next; b3_reg <= b3_next;
        valid_reg <= valid_next; val_reg <= val_next;
        dq_reg <= dq_next; dr_reg <= dr_next; dd_reg <= dd_next; dneg_reg <= dneg_next;
    end

    assign out_beat.result_kind  = kind_reg;
    assign out_beat.result_value = valid_reg ? val_reg : 32'sd0;
    assign out_beat.result_valid = valid_reg;
endmodule

### rtl/core/barometer_temp_pressure_compensation.sv
// Barometer temperature and pressure compensation, top level.
// Depends on btpc_pkg, btpc_ctrl and btpc_datapath.
//
// One item is handled at a time. The division runs in the 32-step radix-2
// divider; the other steps run one per cycle through the single shared 32x32
// multiplier. A zero divisor skips the division and ends the item with
// result_valid low. A result is held on out until taken; a new item is
// accepted once that result has left.
`timescale 1ns / 1ps
module barometer_temp_pressure_compensation
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  btpc_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output btpc_pkg::out_beat_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    btpc_pkg::dp_cmd_t  cmd;
    btpc_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac12_reg <= 32'd0; ac34_reg <= 32'd0; ac56_reg <= 32'd0;
            b12_reg  <= 32'd0; mcmd_reg <= 32'd0; oss_reg  <= 2'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                btpc_pkg::REG_AC1_AC2: ac12_reg <= cfg_data;
                btpc_pkg::REG_AC3_AC4: ac34_reg <= cfg_data;
                btpc_pkg::REG_AC5_AC6: ac56_reg <= cfg_data;
                btpc_pkg::REG_B1_B2:   b12_reg  <= cfg_data;
                btpc_pkg::REG_MC_MD:   mcmd_reg <= cfg_data;
                btpc_pkg::REG_OSS:     oss_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    btpc_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_data.opcode),
        .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat)
    );

    btpc_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_beat(in_data),
        .cal_ac1_ac2(ac12_reg), .cal_ac3_ac4(ac34_reg), .cal_ac5_ac6(ac56_reg),
        .cal_b1_b2(b12_reg), .cal_mc_md(mcmd_reg), .oversampling(oss_reg),
        .out_beat(out_data)
    );
endmodule
